// ===== hdl/qbsps_pkg.sv =====
package qbsps_pkg;

  localparam int unsigned NUM_LANES    = 8;
  localparam int unsigned ARRIVE_WIDTH = 4;
  localparam int unsigned PHASE_WIDTH  = 5;

  localparam int unsigned LANE_A_ST = 0;
  localparam int unsigned LANE_A_RT = 1;
  localparam int unsigned LANE_B_ST = 2;
  localparam int unsigned LANE_B_RT = 3;
  localparam int unsigned LANE_C_ST = 4;
  localparam int unsigned LANE_C_RT = 5;
  localparam int unsigned LANE_D_ST = 6;
  localparam int unsigned LANE_D_RT = 7;

  localparam logic [PHASE_WIDTH-1:0] PH_IDLE      = 5'd0;
  localparam logic [PHASE_WIDTH-1:0] PH_A_ST_A_RT = 5'd1;
  localparam logic [PHASE_WIDTH-1:0] PH_D_ST_D_RT = 5'd2;
  localparam logic [PHASE_WIDTH-1:0] PH_B_ST_B_RT = 5'd3;
  localparam logic [PHASE_WIDTH-1:0] PH_C_ST_C_RT = 5'd4;
  localparam logic [PHASE_WIDTH-1:0] PH_A_ST_B_ST = 5'd5;
  localparam logic [PHASE_WIDTH-1:0] PH_C_ST_D_ST = 5'd6;
  localparam logic [PHASE_WIDTH-1:0] PH_A_RT_C_ST = 5'd7;
  localparam logic [PHASE_WIDTH-1:0] PH_A_ST_D_RT = 5'd8;
  localparam logic [PHASE_WIDTH-1:0] PH_B_RT_D_ST = 5'd9;
  localparam logic [PHASE_WIDTH-1:0] PH_B_ST_C_RT = 5'd10;
  localparam logic [PHASE_WIDTH-1:0] PH_A_ST      = 5'd11;
  localparam logic [PHASE_WIDTH-1:0] PH_D_ST      = 5'd12;
  localparam logic [PHASE_WIDTH-1:0] PH_B_ST      = 5'd13;
  localparam logic [PHASE_WIDTH-1:0] PH_C_ST      = 5'd14;
  localparam logic [PHASE_WIDTH-1:0] PH_A_RT      = 5'd15;
  localparam logic [PHASE_WIDTH-1:0] PH_D_RT      = 5'd16;
  localparam logic [PHASE_WIDTH-1:0] PH_B_RT      = 5'd17;
  localparam logic [PHASE_WIDTH-1:0] PH_C_RT      = 5'd18;
  localparam logic [PHASE_WIDTH-1:0] PH_A_RT_B_RT = 5'd19;
  localparam logic [PHASE_WIDTH-1:0] PH_C_RT_D_RT = 5'd20;

  typedef logic [NUM_LANES-1:0] lane_mask_t;

  typedef struct packed {
    logic [ARRIVE_WIDTH-1:0] arrive_a_straight;
    logic [ARRIVE_WIDTH-1:0] arrive_a_right;
    logic [ARRIVE_WIDTH-1:0] arrive_b_straight;
    logic [ARRIVE_WIDTH-1:0] arrive_b_right;
    logic [ARRIVE_WIDTH-1:0] arrive_c_straight;
    logic [ARRIVE_WIDTH-1:0] arrive_c_right;
    logic [ARRIVE_WIDTH-1:0] arrive_d_straight;
    logic [ARRIVE_WIDTH-1:0] arrive_d_right;
  } in_item_t;

  typedef struct packed {
    lane_mask_t             grant_mask;
    logic [PHASE_WIDTH-1:0] phase_code;
    logic                   all_empty;
  } out_item_t;

  typedef struct packed {
    lane_mask_t             grant;
    logic [PHASE_WIDTH-1:0] phase;
  } pick_t;

  function automatic lane_mask_t lane_bit(input int unsigned idx);
    return lane_mask_t'(1) << idx;
  endfunction

  function automatic pick_t pick_phase(input lane_mask_t nz);
    pick_t p;
    p.grant = '0;
    p.phase = PH_IDLE;
    if (nz[LANE_A_ST]) begin
      if (nz[LANE_A_RT]) begin
        p.grant = lane_bit(LANE_A_ST) | lane_bit(LANE_A_RT); p.phase = PH_A_ST_A_RT;
      end else if (nz[LANE_D_RT]) begin
        p.grant = lane_bit(LANE_A_ST) | lane_bit(LANE_D_RT); p.phase = PH_A_ST_D_RT;
      end else if (nz[LANE_B_ST]) begin
        p.grant = lane_bit(LANE_A_ST) | lane_bit(LANE_B_ST); p.phase = PH_A_ST_B_ST;
      end else begin
        p.grant = lane_bit(LANE_A_ST); p.phase = PH_A_ST;
      end
    end else if (nz[LANE_D_ST]) begin
      if (nz[LANE_D_RT]) begin
        p.grant = lane_bit(LANE_D_ST) | lane_bit(LANE_D_RT); p.phase = PH_D_ST_D_RT;
      end else if (nz[LANE_B_RT]) begin
        p.grant = lane_bit(LANE_B_RT) | lane_bit(LANE_D_ST); p.phase = PH_B_RT_D_ST;
      end else if (nz[LANE_C_ST]) begin
        p.grant = lane_bit(LANE_C_ST) | lane_bit(LANE_D_ST); p.phase = PH_C_ST_D_ST;
      end else begin
        p.grant = lane_bit(LANE_D_ST); p.phase = PH_D_ST;
      end
    end else if (nz[LANE_B_ST]) begin
      if (nz[LANE_B_RT]) begin
        p.grant = lane_bit(LANE_B_ST) | lane_bit(LANE_B_RT); p.phase = PH_B_ST_B_RT;
      end else if (nz[LANE_C_RT]) begin
        p.grant = lane_bit(LANE_B_ST) | lane_bit(LANE_C_RT); p.phase = PH_B_ST_C_RT;
      end else begin
        p.grant = lane_bit(LANE_B_ST); p.phase = PH_B_ST;
      end
    end else if (nz[LANE_C_ST]) begin
      if (nz[LANE_C_RT]) begin
        p.grant = lane_bit(LANE_C_ST) | lane_bit(LANE_C_RT); p.phase = PH_C_ST_C_RT;
      end else if (nz[LANE_A_RT]) begin
        p.grant = lane_bit(LANE_A_RT) | lane_bit(LANE_C_ST); p.phase = PH_A_RT_C_ST;
      end else begin
        p.grant = lane_bit(LANE_C_ST); p.phase = PH_C_ST;
      end
    end else if (nz[LANE_A_RT]) begin
      if (nz[LANE_B_RT]) begin
        p.grant = lane_bit(LANE_A_RT) | lane_bit(LANE_B_RT); p.phase = PH_A_RT_B_RT;
      end else begin
        p.grant = lane_bit(LANE_A_RT); p.phase = PH_A_RT;
      end
    end else if (nz[LANE_D_RT]) begin
      if (nz[LANE_C_RT]) begin
        p.grant = lane_bit(LANE_C_RT) | lane_bit(LANE_D_RT); p.phase = PH_C_RT_D_RT;
      end else begin
        p.grant = lane_bit(LANE_D_RT); p.phase = PH_D_RT;
      end
    end else if (nz[LANE_B_RT]) begin
      p.grant = lane_bit(LANE_B_RT); p.phase = PH_B_RT;
    end else if (nz[LANE_C_RT]) begin
      p.grant = lane_bit(LANE_C_RT); p.phase = PH_C_RT;
    end
    return p;
  endfunction

endpackage

// ===== hdl/queue_based_signal_phase_scheduler_top.sv =====
// Signal phase scheduler for a four-way intersection with eight lane queues
// (straight and right lanes of approaches A to D, grant bit order A straight,
// A right, B straight, ..., D right). Each input transfer is one round: its
// arrivals are added to saturating QUEUE_WIDTH-bit queue counters, a fixed
// priority tree picks one of twenty phases among the nonempty lanes, and each
// granted lane is decremented by one. Phase 0 with an empty grant means every
// queue was empty. Throughput is one round per clock while the output is not
// stalled; the result appears in the output register in the cycle after the
// input transfer. The rate is set by the single saturate, decode and decrement
// pass on the queue registers. Input ready drops only while a result waits in
// the output register and the sink is not taking it.
module queue_based_signal_phase_scheduler_top #(
  parameter int unsigned QUEUE_WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  qbsps_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output qbsps_pkg::out_item_t out_data
);

  localparam int unsigned NL = qbsps_pkg::NUM_LANES;
  localparam int unsigned AW = qbsps_pkg::ARRIVE_WIDTH;

  logic [QUEUE_WIDTH-1:0] queue_r   [NL];
  logic [QUEUE_WIDTH-1:0] queue_nxt [NL];
  logic [AW-1:0]          arrive    [NL];
  logic [QUEUE_WIDTH:0]   sum       [NL];
  logic [QUEUE_WIDTH-1:0] sat       [NL];
  qbsps_pkg::lane_mask_t  nz;
  qbsps_pkg::pick_t       pick;
  qbsps_pkg::out_item_t   out_data_r;
  qbsps_pkg::out_item_t   out_data_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic                   in_xfer;
  logic                   empty_after;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  assign arrive[qbsps_pkg::LANE_A_ST] = in_data.arrive_a_straight;
  assign arrive[qbsps_pkg::LANE_A_RT] = in_data.arrive_a_right;
  assign arrive[qbsps_pkg::LANE_B_ST] = in_data.arrive_b_straight;
  assign arrive[qbsps_pkg::LANE_B_RT] = in_data.arrive_b_right;
  assign arrive[qbsps_pkg::LANE_C_ST] = in_data.arrive_c_straight;
  assign arrive[qbsps_pkg::LANE_C_RT] = in_data.arrive_c_right;
  assign arrive[qbsps_pkg::LANE_D_ST] = in_data.arrive_d_straight;
  assign arrive[qbsps_pkg::LANE_D_RT] = in_data.arrive_d_right;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      sum[i] = {1'b0, queue_r[i]} + (QUEUE_WIDTH+1)'(arrive[i]);
      sat[i] = sum[i][QUEUE_WIDTH] ? '1 : sum[i][QUEUE_WIDTH-1:0];
      nz[i]  = (sat[i] != '0);
    end
    pick = qbsps_pkg::pick_phase(nz);
    empty_after = 1'b1;
    for (int i = 0; i < NL; i++) begin
      queue_nxt[i] = sat[i] - QUEUE_WIDTH'(pick.grant[i]);
      if (queue_nxt[i] != '0) begin
        empty_after = 1'b0;
      end
    end
    out_data_nxt.grant_mask = pick.grant;
    out_data_nxt.phase_code = pick.phase;
    out_data_nxt.all_empty  = empty_after;
    out_valid_nxt = in_xfer || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < NL; i++) begin
        queue_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        for (int i = 0; i < NL; i++) begin
          queue_r[i] <= queue_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_idle_iff_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.phase_code == qbsps_pkg::PH_IDLE) ==
                     (out_data_r.grant_mask == '0)))
    else $error("idle phase and empty grant disagree");

  a_idle_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.phase_code == qbsps_pkg::PH_IDLE) |-> out_data_r.all_empty)
    else $error("idle phase reported with a nonempty queue");

  a_grant_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($countones(out_data_r.grant_mask) <= 2))
    else $error("more than two lanes granted");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while result is stalled");

  a_reset_clears_valid: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");
`endif

endmodule

// ===== tb/qbsps_phase_checker.sv =====
`timescale 1ns / 1ps

module qbsps_phase_checker
  import qbsps_pkg::*;
#(
  parameter int unsigned QUEUE_WIDTH = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatches,
  output int        outstanding
);

  localparam logic [QUEUE_WIDTH-1:0] QUEUE_FULL = '1;

  localparam lane_mask_t M_AS = lane_mask_t'(1) << LANE_A_ST;
  localparam lane_mask_t M_AR = lane_mask_t'(1) << LANE_A_RT;
  localparam lane_mask_t M_BS = lane_mask_t'(1) << LANE_B_ST;
  localparam lane_mask_t M_BR = lane_mask_t'(1) << LANE_B_RT;
  localparam lane_mask_t M_CS = lane_mask_t'(1) << LANE_C_ST;
  localparam lane_mask_t M_CR = lane_mask_t'(1) << LANE_C_RT;
  localparam lane_mask_t M_DS = lane_mask_t'(1) << LANE_D_ST;
  localparam lane_mask_t M_DR = lane_mask_t'(1) << LANE_D_RT;

  logic [QUEUE_WIDTH-1:0] lane_count [NUM_LANES];
  out_item_t              pending_grants [$];
  out_item_t              oldest;
  int                     fail_total = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic void choose_phase(input lane_mask_t busy, output lane_mask_t lanes,
                                       output logic [PHASE_WIDTH-1:0] ph);
    lanes = '0;
    ph    = PH_IDLE;
    if ((busy & M_AS) != 0) begin
      if ((busy & M_AR) != 0) begin
        lanes = M_AS | M_AR; ph = PH_A_ST_A_RT;
      end else if ((busy & M_DR) != 0) begin
        lanes = M_AS | M_DR; ph = PH_A_ST_D_RT;
      end else if ((busy & M_BS) != 0) begin
        lanes = M_AS | M_BS; ph = PH_A_ST_B_ST;
      end else begin
        lanes = M_AS; ph = PH_A_ST;
      end
    end else if ((busy & M_DS) != 0) begin
      if ((busy & M_DR) != 0) begin
        lanes = M_DS | M_DR; ph = PH_D_ST_D_RT;
      end else if ((busy & M_BR) != 0) begin
        lanes = M_DS | M_BR; ph = PH_B_RT_D_ST;
      end else if ((busy & M_CS) != 0) begin
        lanes = M_DS | M_CS; ph = PH_C_ST_D_ST;
      end else begin
        lanes = M_DS; ph = PH_D_ST;
      end
    end else if ((busy & M_BS) != 0) begin
      if ((busy & M_BR) != 0) begin
        lanes = M_BS | M_BR; ph = PH_B_ST_B_RT;
      end else if ((busy & M_CR) != 0) begin
        lanes = M_BS | M_CR; ph = PH_B_ST_C_RT;
      end else begin
        lanes = M_BS; ph = PH_B_ST;
      end
    end else if ((busy & M_CS) != 0) begin
      if ((busy & M_CR) != 0) begin
        lanes = M_CS | M_CR; ph = PH_C_ST_C_RT;
      end else if ((busy & M_AR) != 0) begin
        lanes = M_CS | M_AR; ph = PH_A_RT_C_ST;
      end else begin
        lanes = M_CS; ph = PH_C_ST;
      end
    end else if ((busy & M_AR) != 0) begin
      if ((busy & M_BR) != 0) begin
        lanes = M_AR | M_BR; ph = PH_A_RT_B_RT;
      end else begin
        lanes = M_AR; ph = PH_A_RT;
      end
    end else if ((busy & M_DR) != 0) begin
      if ((busy & M_CR) != 0) begin
        lanes = M_DR | M_CR; ph = PH_C_RT_D_RT;
      end else begin
        lanes = M_DR; ph = PH_D_RT;
      end
    end else if ((busy & M_BR) != 0) begin
      lanes = M_BR; ph = PH_B_RT;
    end else if ((busy & M_CR) != 0) begin
      lanes = M_CR; ph = PH_C_RT;
    end
  endfunction

  function automatic out_item_t serve_round(input in_item_t r);
    logic [ARRIVE_WIDTH-1:0] arrivals [NUM_LANES];
    logic [QUEUE_WIDTH:0]    sum;
    lane_mask_t              busy;
    lane_mask_t              lanes;
    logic [PHASE_WIDTH-1:0]  ph;
    out_item_t               res;
    arrivals[LANE_A_ST] = r.arrive_a_straight;
    arrivals[LANE_A_RT] = r.arrive_a_right;
    arrivals[LANE_B_ST] = r.arrive_b_straight;
    arrivals[LANE_B_RT] = r.arrive_b_right;
    arrivals[LANE_C_ST] = r.arrive_c_straight;
    arrivals[LANE_C_RT] = r.arrive_c_right;
    arrivals[LANE_D_ST] = r.arrive_d_straight;
    arrivals[LANE_D_RT] = r.arrive_d_right;
    busy = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      sum = {1'b0, lane_count[i]} + (QUEUE_WIDTH+1)'(arrivals[i]);
      lane_count[i] = (sum > {1'b0, QUEUE_FULL}) ? QUEUE_FULL : sum[QUEUE_WIDTH-1:0];
      busy[i] = (lane_count[i] != 0);
    end
    choose_phase(busy, lanes, ph);
    res.all_empty = 1'b1;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (lanes[i]) lane_count[i] = lane_count[i] - QUEUE_WIDTH'(1);
      if (lane_count[i] != 0) res.all_empty = 1'b0;
    end
    res.grant_mask = lanes;
    res.phase_code = ph;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LANES; i++) lane_count[i] = '0;
      pending_grants.delete();
    end else begin
      if (in_valid && in_ready) pending_grants.push_back(serve_round(in_data));
      if (out_valid && out_ready) begin
        if (pending_grants.size() == 0) begin
          $display("%0t: unexpected result transfer %h, nothing expected", $realtime,
                   out_data);
          fail_total++;
        end else begin
          oldest = pending_grants.pop_front();
          if (out_data.grant_mask !== oldest.grant_mask) begin
            $display("%0t: grant_mask expected %h actual %h", $realtime,
                     oldest.grant_mask, out_data.grant_mask);
            fail_total++;
          end
          if (out_data.phase_code !== oldest.phase_code) begin
            $display("%0t: phase_code expected %0d actual %0d", $realtime,
                     oldest.phase_code, out_data.phase_code);
            fail_total++;
          end
          if (out_data.all_empty !== oldest.all_empty) begin
            $display("%0t: all_empty expected %b actual %b", $realtime,
                     oldest.all_empty, out_data.all_empty);
            fail_total++;
          end
        end
      end
    end
    mismatches  <= fail_total;
    outstanding <= pending_grants.size();
  end

endmodule

// ===== tb/queue_based_signal_phase_scheduler_top_tb.sv =====
`timescale 1ns / 1ps

module queue_based_signal_phase_scheduler_top_tb;
  import qbsps_pkg::*;

  localparam int unsigned QUEUE_WIDTH = 8;
  localparam int          STALL_LIMIT = 5000;

  localparam lane_mask_t M_AS = lane_mask_t'(1) << LANE_A_ST;
  localparam lane_mask_t M_AR = lane_mask_t'(1) << LANE_A_RT;
  localparam lane_mask_t M_BS = lane_mask_t'(1) << LANE_B_ST;
  localparam lane_mask_t M_BR = lane_mask_t'(1) << LANE_B_RT;
  localparam lane_mask_t M_CS = lane_mask_t'(1) << LANE_C_ST;
  localparam lane_mask_t M_CR = lane_mask_t'(1) << LANE_C_RT;
  localparam lane_mask_t M_DS = lane_mask_t'(1) << LANE_D_ST;
  localparam lane_mask_t M_DR = lane_mask_t'(1) << LANE_D_RT;

  typedef enum int {TRAFFIC_LIGHT, TRAFFIC_QUIET, TRAFFIC_MIXED, TRAFFIC_SURGE} traffic_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int mismatches;
  int outstanding;
  int send_idle_pct = 11;
  int recv_idle_pct = 87;
  int quiet_cycles = 0;

  queue_based_signal_phase_scheduler_top #(
    .QUEUE_WIDTH(QUEUE_WIDTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  qbsps_phase_checker #(
    .QUEUE_WIDTH(QUEUE_WIDTH)
  ) phase_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic in_item_t arrivals(input lane_mask_t lanes,
                                        input logic [ARRIVE_WIDTH-1:0] n);
    logic [$bits(in_item_t)-1:0] v;
    v = '0;
    for (int i = 0; i < NUM_LANES; i++)
      if (lanes[i]) v[(NUM_LANES-1-i)*ARRIVE_WIDTH +: ARRIVE_WIDTH] = n;
    return in_item_t'(v);
  endfunction

  function automatic in_item_t random_round(input traffic_t mode, input int surge_lane);
    logic [$bits(in_item_t)-1:0] v;
    v = '0;
    if (mode == TRAFFIC_MIXED) return in_item_t'($urandom);
    if (mode == TRAFFIC_QUIET) return in_item_t'(v);
    for (int i = 0; i < NUM_LANES; i++) begin
      if (mode == TRAFFIC_SURGE && i == surge_lane) begin
        v[(NUM_LANES-1-i)*ARRIVE_WIDTH +: ARRIVE_WIDTH] =
          ARRIVE_WIDTH'($urandom_range(12, 15));
      end else if ($urandom_range(0, 15) == 0) begin
        v[(NUM_LANES-1-i)*ARRIVE_WIDTH +: ARRIVE_WIDTH] =
          ($urandom_range(0, 7) == 0) ? ARRIVE_WIDTH'($urandom_range(1, 15))
                                      : ARRIVE_WIDTH'($urandom_range(1, 3));
      end
    end
    return in_item_t'(v);
  endfunction

  // hold valid and payload until the transfer, then advance to the next falling edge
  task automatic send_round(input in_item_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    traffic_t mode;
    int       seg_left;
    int       surge_lane;
    int       pick;
    seg_left   = 0;
    surge_lane = 0;
    mode       = TRAFFIC_LIGHT;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_round(arrivals('0, 4'd0));
    send_round(arrivals(M_AS, 4'd1));
    send_round(arrivals(M_DS, 4'd1));
    send_round(arrivals(M_BS, 4'd1));
    send_round(arrivals(M_CS, 4'd1));
    send_round(arrivals(M_AR, 4'd1));
    send_round(arrivals(M_DR, 4'd1));
    send_round(arrivals(M_BR, 4'd1));
    send_round(arrivals(M_CR, 4'd1));
    send_round(arrivals(M_AS | M_AR, 4'd1));
    send_round(arrivals(M_AS | M_DR, 4'd1));
    send_round(arrivals(M_AS | M_BS, 4'd1));
    send_round(arrivals(M_DS | M_DR, 4'd1));
    send_round(arrivals(M_DS | M_BR, 4'd1));
    send_round(arrivals(M_DS | M_CS, 4'd1));
    send_round(arrivals(M_BS | M_BR, 4'd1));
    send_round(arrivals(M_BS | M_CR, 4'd1));
    send_round(arrivals(M_CS | M_CR, 4'd1));
    send_round(arrivals(M_CS | M_AR, 4'd1));
    send_round(arrivals(M_AR | M_BR, 4'd1));
    send_round(arrivals(M_CR | M_DR, 4'd1));
    send_round(arrivals('1, 4'hF));
    send_round(arrivals('1, 4'hF));
    send_round(arrivals('0, 4'd0));

    for (int stage = 0; stage < 3; stage++) begin
      send_idle_pct = (stage == 0) ? 11 : (stage == 1) ? 87 : 0;
      recv_idle_pct = (stage == 0) ? 87 : (stage == 1) ? 11 : 0;
      for (int n = 0; n < 667; n++) begin
        if (seg_left == 0) begin
          pick = $urandom_range(0, 19);
          if (pick < 10) begin
            mode = TRAFFIC_LIGHT; seg_left = $urandom_range(10, 40);
          end else if (pick < 15) begin
            mode = TRAFFIC_QUIET; seg_left = $urandom_range(5, 30);
          end else if (pick < 19) begin
            mode = TRAFFIC_MIXED; seg_left = $urandom_range(1, 5);
          end else begin
            mode = TRAFFIC_SURGE; seg_left = $urandom_range(10, 22);
            surge_lane = $urandom_range(0, NUM_LANES - 1);
          end
        end
        send_round(random_round(mode, surge_lane));
        seg_left--;
      end
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== queue_based_signal_phase_scheduler_top.f =====
hdl/qbsps_pkg.sv
hdl/queue_based_signal_phase_scheduler_top.sv
tb/qbsps_phase_checker.sv
tb/queue_based_signal_phase_scheduler_top_tb.sv
